>>> sv/max_heap_increase_key_defines.svh
// Assertion macros shared by the max-heap increase-key RTL.
`ifndef MAX_HEAP_INCREASE_KEY_DEFINES_SVH
`define MAX_HEAP_INCREASE_KEY_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MHIK_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MHIK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mhik_pkg.sv
// Shared types, codes and defaults for the max-heap increase-key block.
`default_nettype none

package mhik_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int KEY_WIDTH_DEF  = 32;

  localparam int OP_W  = 2;
  localparam int POS_W = 11;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_APPEND   = 2'd0;
  localparam logic [OP_W-1:0] OP_INCREASE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_POS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_UP_RD,
    S_UP_CMP,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_in;
    logic            do_append;
    logic            set_error;
    logic [ST_W-1:0] err_status;
    logic            rd_pos;
    logic            take_read;
    logic            init_inc;
    logic            rd_parent;
    logic            move_down;
    logic            finish_inc;
    logic            load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] opcode;
    logic            full;
    logic            pos_bad;
    logic            idx_zero;
    logic            parent_lt;
    logic            out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/mhik_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mhik_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/mhik_ctrl.sv
// Controller state machine that sequences append, read and increase-key operations.
`default_nettype none

module mhik_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire mhik_pkg::sts_t sts,
  output      mhik_pkg::cmd_t cmd
);

  import mhik_pkg::*;

  `include "max_heap_increase_key_defines.svh"

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.opcode == OP_APPEND) begin
          if (sts.full) begin
            cmd.set_error  = 1'b1;
            cmd.err_status = ST_FULL;
          end else begin
            cmd.do_append = 1'b1;
          end
          state_nxt = S_EMIT;
        end else if ((sts.opcode inside {OP_READ, OP_INCREASE}) && !sts.pos_bad) begin
          cmd.rd_pos = 1'b1;
          state_nxt  = S_FETCH;
        end else begin
          cmd.set_error  = 1'b1;
          cmd.err_status = ST_BAD_POS;
          state_nxt      = S_EMIT;
        end
      end
      S_FETCH: begin
        if (sts.opcode == OP_READ) begin
          cmd.take_read = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          cmd.init_inc = 1'b1;
          state_nxt    = S_UP_RD;
        end
      end
      S_UP_RD: begin
        if (sts.idx_zero) begin
          cmd.finish_inc = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.parent_lt) begin
          cmd.move_down = 1'b1;
          state_nxt     = S_UP_RD;
        end else begin
          cmd.finish_inc = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A result is only handed to the output register when that register can take it.
  `MHIK_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.load_out, sts.out_free, "output overrun")
  // Every accepted word is decoded in the following cycle.
  `MHIK_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready, state_r == S_DECODE, "accepted word not decoded")
  // The input is only open while no operation is in progress.
  `MHIK_ASSERT_NOW(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE, "ready outside idle")

endmodule

`default_nettype wire

>>> sv/mhik_dp.sv
// Datapath: heap store, element count, sift-up registers and the output register.
`default_nettype none

module mhik_dp #(
  parameter int HEAP_DEPTH = mhik_pkg::HEAP_DEPTH_DEF,
  parameter int KEY_WIDTH  = mhik_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mhik_pkg::cmd_t              cmd,
  output      mhik_pkg::sts_t              sts,
  input  wire logic [mhik_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [mhik_pkg::POS_W-1:0]  in_position,
  input  wire logic signed [mhik_pkg::VAL_W-1:0] in_operand,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [mhik_pkg::POS_W-1:0]  out_position,
  output      logic signed [mhik_pkg::VAL_W-1:0] out_key,
  output      logic [mhik_pkg::ST_W-1:0]   out_status
);

  import mhik_pkg::*;

  `include "max_heap_increase_key_defines.svh"

  localparam int AW   = $clog2(HEAP_DEPTH);
  localparam int CW   = $clog2(HEAP_DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int SW   = ((KEY_WIDTH > VAL_W) ? KEY_WIDTH : VAL_W) + 1;
  localparam logic signed [KEY_WIDTH-1:0] KEY_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
  localparam logic signed [KEY_WIDTH-1:0] KEY_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  // Captured input word.
  logic [OP_W-1:0]              op_r;
  logic [POS_W-1:0]             pos_r;
  logic signed [VAL_W-1:0]      val_r;

  logic [CW-1:0]                count_r;
  logic [AW-1:0]                idx_r;
  logic signed [KEY_WIDTH-1:0]  cur_key_r;

  logic [POS_W-1:0]             res_pos_r;
  logic signed [KEY_WIDTH-1:0]  res_key_r;
  logic [ST_W-1:0]              res_st_r;

  logic                         out_valid_r;
  logic [POS_W-1:0]             out_pos_r;
  logic signed [VAL_W-1:0]      out_key_r;
  logic [ST_W-1:0]              out_st_r;

  // Memory port signals.
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [KEY_WIDTH-1:0]         mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [KEY_WIDTH-1:0]         mem_rdata;

  logic [POS_W-1:0]             pos_m1;
  logic [AW-1:0]                parent_idx;
  logic signed [KEY_WIDTH-1:0]  app_key;
  logic signed [KEY_WIDTH-1:0]  rd_key;
  logic signed [SW-1:0]         sum;
  logic signed [KEY_WIDTH-1:0]  sat_key;

  assign pos_m1     = pos_r - POS_W'(1);
  assign parent_idx = (idx_r - AW'(1)) >> 1;
  assign app_key    = KEY_WIDTH'(val_r);
  assign rd_key     = $signed(mem_rdata);

  // Exact sum of the stored key and the delta, clamped to the key range.
  always_comb begin
    sum = SW'(rd_key) + SW'(val_r);
    if (sum > SW'(KEY_MAX)) begin
      sat_key = KEY_MAX;
    end else if (sum < SW'(KEY_MIN)) begin
      sat_key = KEY_MIN;
    end else begin
      sat_key = KEY_WIDTH'(sum);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = cur_key_r;
    if (cmd.do_append) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(count_r);
      mem_wdata = app_key;
    end else if (cmd.move_down) begin
      mem_we    = 1'b1;
      mem_wdata = mem_rdata;
    end else if (cmd.finish_inc) begin
      mem_we    = 1'b1;
    end
  end

  assign mem_re    = cmd.rd_pos | cmd.rd_parent;
  assign mem_raddr = cmd.rd_parent ? parent_idx : AW'(pos_m1);

  mhik_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_opcode;
      pos_r <= in_position;
      val_r <= in_operand;
    end
    if (cmd.init_inc) begin
      idx_r     <= AW'(pos_m1);
      cur_key_r <= sat_key;
    end else if (cmd.move_down) begin
      idx_r     <= parent_idx;
    end
    if (cmd.set_error) begin
      res_pos_r <= '0;
      res_key_r <= '0;
      res_st_r  <= cmd.err_status;
    end else if (cmd.do_append) begin
      res_pos_r <= POS_W'(count_r + CW'(1));
      res_key_r <= app_key;
      res_st_r  <= ST_OK;
    end else if (cmd.take_read) begin
      res_pos_r <= pos_r;
      res_key_r <= rd_key;
      res_st_r  <= ST_OK;
    end else if (cmd.finish_inc) begin
      res_pos_r <= POS_W'({1'b0, idx_r} + (AW + 1)'(1));
      res_key_r <= cur_key_r;
      res_st_r  <= ST_OK;
    end
    if (cmd.load_out) begin
      out_pos_r <= res_pos_r;
      out_key_r <= VAL_W'(res_key_r);
      out_st_r  <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.do_append) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.opcode    = op_r;
  assign sts.full      = (count_r == CW'(HEAP_DEPTH));
  assign sts.pos_bad   = (pos_r == '0) || (CMPW'(pos_r) > CMPW'(count_r));
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.parent_lt = (rd_key < cur_key_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_position = out_pos_r;
  assign out_key      = out_key_r;
  assign out_status   = out_st_r;

  `MHIK_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(HEAP_DEPTH), "count above depth")
  `MHIK_ASSERT_NOW(a_no_rw_clash, clk, rst_n, mem_we, !mem_re, "store read and written together")
  `MHIK_ASSERT_NEXT(a_count_hold, clk, rst_n, !cmd.do_append, $stable(count_r), "count moved without append")

endmodule

`default_nettype wire

>>> sv/max_heap_increase_key.sv
// Top level of the binary max-heap with append, read and increase-key operations.
//
// One input word carries one operation: opcode in in_tuser, position and operand in
// in_tdata. Every accepted word yields exactly one output word with the final
// position and key in out_tdata and the status code in out_tuser.
// Append writes the key behind the last element without reordering; read returns the
// key at a 1-based position; increase adds a saturating delta to the key at a position
// and sifts it up while its parent is strictly smaller.
// A word is taken only while the block is idle. Append, store-full answers and
// position errors go from decode straight to the emit state; a read passes through
// a fetch state first, and an increase fetches the key and then runs the sift-up loop.
// Each level of the sift-up loop is one read of the parent from the single-read heap
// RAM, whose data arrives registered, and then a compare and a write.
// From the emit state the result goes to the output register once that is free.
// The output register holds its word until out_tready; the block goes on accepting and
// working on the next word meanwhile, and only waits when a new result is ready while
// the previous one still has not been taken.
// Reset (rst_n low at a clock edge) empties the heap count and the output register.
// The heap RAM is not cleared: only entries below the count are ever read.

`default_nettype none

module max_heap_increase_key #(
  parameter int HEAP_DEPTH = mhik_pkg::HEAP_DEPTH_DEF,
  parameter int KEY_WIDTH  = mhik_pkg::KEY_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [47:0] in_tdata,   // [10:0] position, [42:11] operand_value, [47:43] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] opcode
  // Result channel.
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,  // [10:0] result_position, [42:11] result_key, [47:43] zero
  output      logic [1:0]  out_tuser   // [1:0] status
);

  import mhik_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [POS_W-1:0]        res_position;
  logic signed [VAL_W-1:0] res_key;
  logic [ST_W-1:0]         res_status;

  // The controller decides what happens in each cycle; the datapath owns all storage.
  mhik_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mhik_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_opcode    (in_tuser),
    .in_position  (in_tdata[10:0]),
    .in_operand   ($signed(in_tdata[42:11])),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_position (res_position),
    .out_key      (res_key),
    .out_status   (res_status)
  );

  // Pack the result word; the unused top bits of the data bus stay zero.
  assign out_tdata = {5'd0, res_key, res_position};
  assign out_tuser = res_status;

endmodule

`default_nettype wire

>>> test/tb_max_heap_increase_key.sv
// Self-checking testbench for the max-heap increase-key block.
`timescale 1ns / 1ps

module tb_max_heap_increase_key;
  import mhik_pkg::*;

  // The block defines no operation for this opcode and answers it as a bad position.
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  localparam int                      HEAP_DEPTH = HEAP_DEPTH_DEF;
  localparam logic signed [VAL_W-1:0] KEY_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] KEY_MIN    = 32'sh8000_0000;

  // Cycles without any accepted word before the run is declared hung. The longest
  // legitimate quiet stretch is the deliberate receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  // One operation as the sender sees it, plus its idle time and whether it must
  // wait for every outstanding result before it is offered.
  typedef struct {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      gap;
    bit                      drain;
  } heap_op_t;

  typedef struct {
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] key;
    logic [ST_W-1:0]         status;
  } heap_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;  // [10:0] position, [42:11] operand_value, [47:43] zero
  logic [1:0]  in_tuser   = '0;  // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // [10:0] result_position, [42:11] result_key, [47:43] zero
  logic [1:0]  out_tuser;        // [1:0] status

  max_heap_increase_key dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Operations waiting to be sent, and the results the heap mirror predicts for
  // words the block has already taken, oldest first.
  heap_op_t     pending_ops[$];
  heap_result_t expected_results[$];

  // Mirror of the heap contents, updated as each word is accepted.
  logic signed [VAL_W-1:0] key_mirror [HEAP_DEPTH];
  int                      mirror_count = 0;

  // Element count as the stimulus generator expects it to be once all queued
  // operations have run; used to aim positions at live entries and to steer the op mix.
  int planned_count = 0;
  int planned_ops   = 0;
  bit sender_burst  = 1'b0;

  heap_op_t cur_op;
  bit       offering  = 1'b0;
  bit       word_sent = 1'b0;
  int       gap_left  = 0;

  bit rx_calm      = 1'b0;
  bit word_taken   = 1'b0;
  int stall_left   = 0;
  int hold_left    = 0;
  int hold_request = 0;
  int results_seen = 0;

  int error_count = 0;
  int quiet_cycles = 0;

  // Applies one operation to the heap mirror and returns the word the block
  // must answer with.
  function automatic heap_result_t apply_heap_op(heap_op_t w);
    heap_result_t            res;
    int                      idx;
    int                      par;
    logic signed [VAL_W:0]   sum;
    logic signed [VAL_W-1:0] swap_key;
    res.pos    = '0;
    res.key    = '0;
    res.status = ST_BAD_POS;
    if (w.op == OP_APPEND) begin
      // Appends go behind the last key with no reordering.
      if (mirror_count >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        key_mirror[mirror_count] = w.val;
        mirror_count++;
        res.pos    = POS_W'(mirror_count);
        res.key    = w.val;
        res.status = ST_OK;
      end
    end else if (w.op == OP_UNDEF || w.pos == 0 || w.pos > mirror_count) begin
      // Error answer already set up above.
    end else if (w.op == OP_READ) begin
      res.pos    = w.pos;
      res.key    = key_mirror[w.pos - 1];
      res.status = ST_OK;
    end else begin
      idx = w.pos - 1;
      // Add in one extra bit so the clamp sees the true sum.
      sum = key_mirror[idx] + w.val;
      if (sum > KEY_MAX) begin
        key_mirror[idx] = KEY_MAX;
      end else if (sum < KEY_MIN) begin
        key_mirror[idx] = KEY_MIN;
      end else begin
        key_mirror[idx] = sum[VAL_W-1:0];
      end
      // Climb while the parent is strictly smaller; an equal parent stops it.
      while (idx > 0) begin
        par = (idx - 1) / 2;
        if (!(key_mirror[par] < key_mirror[idx])) break;
        swap_key        = key_mirror[par];
        key_mirror[par] = key_mirror[idx];
        key_mirror[idx] = swap_key;
        idx             = par;
      end
      res.pos    = POS_W'(idx + 1);
      res.key    = key_mirror[idx];
      res.status = ST_OK;
    end
    return res;
  endfunction

  task automatic push_op(input logic [OP_W-1:0] op, input int pos,
                         input logic signed [VAL_W-1:0] val, input bit drain);
    heap_op_t w;
    w.op    = op;
    w.pos   = POS_W'(pos);
    w.val   = val;
    w.gap   = sender_burst ? 0 : $urandom_range(0, 6);
    w.drain = drain;
    if (op == OP_APPEND && planned_count < HEAP_DEPTH) planned_count++;
    pending_ops.insert(pending_ops.size(), w);
  endtask

  // Builds one random operation. Appends dominate until the store is full so that
  // the heap grows deep enough for long climbs; afterwards most words are reads
  // and increases, with a few appends that must be refused.
  task automatic add_random_op(input bit drain);
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] val;
    int                      pos;
    int                      top;
    int                      pick;
    top = (planned_count > 0) ? planned_count : 1;
    planned_ops++;
    if (planned_ops % 60 == 0) sender_burst = ~sender_burst;
    pick = $urandom_range(0, 99);
    if (pick < ((planned_count < HEAP_DEPTH) ? 75 : 25)) begin
      op = OP_APPEND;
    end else begin
      pick = $urandom_range(0, 99);
      op = (pick < 60) ? OP_INCREASE : (pick < 96) ? OP_READ : OP_UNDEF;
    end

    // Position: mostly live entries, with a bias toward the leaves, plus the
    // edges just outside the heap and arbitrary values over all eleven bits.
    pick = $urandom_range(0, 19);
    if (op == OP_APPEND || pick == 2) pos = $urandom_range(0, 2047);
    else if (pick == 0)               pos = 0;
    else if (pick == 1)               pos = planned_count + 1;
    else if (pick == 3)               pos = top;
    else if (pick < 10)               pos = $urandom_range(top / 2 + 1, top);
    else                              pos = $urandom_range(1, top);

    pick = $urandom_range(0, 19);
    if (op == OP_APPEND) begin
      if (pick == 0)      val = KEY_MIN;
      else if (pick == 1) val = KEY_MAX;
      else if (pick == 2) val = '0;
      else if (pick == 3) val = -1;
      else                val = $urandom;
    end else begin
      // Deltas: small raises drive multi-level climbs, large ones saturate.
      if (pick < 8)       val = $urandom_range(1, 1000);
      else if (pick < 11) val = $urandom;
      else if (pick < 12) val = KEY_MAX;
      else if (pick < 13) val = KEY_MIN;
      else if (pick < 16) val = -$urandom_range(1, 1000);
      else if (pick < 18) val = '0;
      else                val = $urandom_range(1000, 32'h7FFF_FFFF);
    end
    push_op(op, pos, val, drain);
  endtask

  // Input side: record an accepted word and predict its answer.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.insert(expected_results.size(), apply_heap_op(cur_op));
      word_sent = 1'b1;
    end
  end

  // Sender: offers queued operations, honoring each item's gap and drain flag.
  always @(negedge clk) begin
    if (word_sent) begin
      word_sent = 1'b0;
      offering  = 1'b0;
      gap_left  = cur_op.gap;
    end
    if (rst_n && !offering) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && expected_results.size() != 0)) begin
        cur_op   = pending_ops.pop_front();
        offering = 1'b1;
      end
    end
    in_tvalid <= offering;
    if (offering) begin
      in_tdata <= {5'b0, cur_op.val, cur_op.pos};
      in_tuser <= cur_op.op;
    end
  end

  // Output side: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      word_taken = 1'b1;
      results_seen++;
      if (results_seen % 80 == 0) rx_calm = ~rx_calm;
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result word: pos %0d key %0d status %0d",
                   out_tdata[10:0], $signed(out_tdata[42:11]), out_tuser);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[10:0] !== want.pos || out_tdata[42:11] !== want.key ||
            out_tuser !== want.status) begin
          error_count++;
          if (error_count <= 10)
            $display({"result mismatch: expected pos %0d key %0d status %0d, ",
                      "got pos %0d key %0d status %0d"},
                     want.pos, want.key, want.status, out_tdata[10:0],
                     $signed(out_tdata[42:11]), out_tuser);
        end
      end
    end
  end

  // Receiver: random stalls per word, calm stretches, and a long hold-off when
  // the stimulus asks for one.
  always @(negedge clk) begin
    if (word_taken) begin
      word_taken = 1'b0;
      stall_left = rx_calm ? 0 : $urandom_range(0, 6);
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: a stretch with no accepted word on either side means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: errors on an empty heap, the key extremes, both saturation
    // directions, a climb to the root, and a climb stopped by an equal parent.
    push_op(OP_READ, 1, 32'sd0, 1'b0);
    push_op(OP_INCREASE, 1, 32'sd5, 1'b0);
    push_op(OP_APPEND, 2047, KEY_MIN, 1'b0);
    push_op(OP_APPEND, 0, KEY_MAX, 1'b0);
    push_op(OP_READ, 2, 32'sd0, 1'b0);
    push_op(OP_READ, 0, 32'sd0, 1'b0);
    push_op(OP_READ, 3, 32'sd0, 1'b0);
    push_op(OP_UNDEF, 1, 32'sd7, 1'b0);
    push_op(OP_INCREASE, 1, -32'sd1, 1'b0);
    push_op(OP_INCREASE, 2, 32'sd1, 1'b0);
    push_op(OP_APPEND, 0, 32'sd5, 1'b0);
    push_op(OP_APPEND, 0, 32'sd5, 1'b0);
    push_op(OP_INCREASE, 4, 32'sd0, 1'b0);
    push_op(OP_APPEND, 0, -32'sd3, 1'b0);
    push_op(OP_INCREASE, 5, 32'sd8, 1'b0);
    push_op(OP_INCREASE, 5, KEY_MAX, 1'b0);
    push_op(OP_INCREASE, 1, KEY_MIN, 1'b0);
    push_op(OP_INCREASE, 4, KEY_MIN, 1'b0);
    push_op(OP_INCREASE, 3, 32'sd0, 1'b0);
    push_op(OP_READ, 5, 32'sd0, 1'b0);
    push_op(OP_READ, 6, 32'sd0, 1'b0);
    push_op(OP_UNDEF, 0, KEY_MIN, 1'b0);

    repeat (400) add_random_op(1'b0);

    // Hold the result channel while the sender keeps offering, so the block
    // backs up and stalls its input.
    while (pending_ops.size() > 16) @(posedge clk);
    hold_request = HOLD_CYCLES;

    // Then let the sender wait for every outstanding answer before going on.
    add_random_op(1'b1);
    while (planned_count < HEAP_DEPTH) add_random_op(1'b0);
    repeat (150) add_random_op(1'b0);

    while (pending_ops.size() != 0 || offering || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
